// ===== sv/word_bigram_count_min_sketch_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the count-min sketch unit.
// ----------------------------------------------------------------------------
`ifndef WORD_BIGRAM_COUNT_MIN_SKETCH_UNIT_MACROS_SVH
`define WORD_BIGRAM_COUNT_MIN_SKETCH_UNIT_MACROS_SVH

// check under reset qualification
`define WBCMS_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check at every edge, reset included
`define WBCMS_CHECK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/wbcms_pkg.sv =====
// ----------------------------------------------------------------------------
// wbcms_pkg
// Types, constants and hash helpers of the word bigram count-min sketch unit.
// ----------------------------------------------------------------------------
package wbcms_pkg;

  localparam int ROWS        = 24;
  localparam int COLUMNS     = 4096;
  localparam int ROW_W       = 5;
  localparam int COL_W       = 12;
  localparam int CCNT_W      = 13;
  localparam int CNT_AW      = ROW_W + COL_W;
  localparam int CNT_DEPTH   = ROWS * COLUMNS;
  localparam int COEF_AW     = ROW_W + 1;
  localparam int COEF_DEPTH  = 2 * ROWS;

  localparam logic [31:0] SEED_RESET = 32'hf00df00d;
  localparam logic [31:0] MIX_C1     = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2     = 32'h1b873593;
  localparam logic [31:0] MIX_ADD    = 32'he6546b64;
  localparam logic [31:0] FIN_M1     = 32'h85ebca6b;
  localparam logic [31:0] FIN_M2     = 32'hc2b2ae35;
  localparam logic [7:0]  CH_NL      = 8'h0a;

  localparam logic [CCNT_W-1:0] CCNT_RESET = CCNT_W'(COLUMNS);

  localparam logic [1:0] FUNC_BYTE = 2'd0;
  localparam logic [1:0] FUNC_LOAD = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;
  localparam logic [1:0] FUNC_NOP  = 2'd3;

  localparam logic REG_SEED = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_MIX1, S_MIX2, S_MIX3,
    S_TAIL1, S_TAIL2, S_TAIL3,
    S_FMIX1, S_FMIX2, S_FMIX3,
    S_RDA, S_RDB, S_MULH, S_MODS, S_DIV, S_CRD, S_CWR,
    S_RDC, S_RDC2, S_OUT
  } state_t;

  function automatic logic is_word_byte(input logic [7:0] c);
    return c inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39], 8'h2d};
  endfunction

  function automatic logic [31:0] rotl15(input logic [31:0] x);
    return {x[16:0], x[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] x);
    return {x[18:0], x[31:19]};
  endfunction

endpackage

// ===== sv/wbcms_ram.sv =====
// ----------------------------------------------------------------------------
// wbcms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wbcms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/wbcms_mod.sv =====
// ----------------------------------------------------------------------------
// wbcms_mod
// Bit-serial remainder of a 32-bit value by the active column count.
// ----------------------------------------------------------------------------
`include "word_bigram_count_min_sketch_unit_macros.svh"

module wbcms_mod (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [31:0]                  dividend,
  input  logic [wbcms_pkg::CCNT_W-1:0] divisor,
  output logic                         done,
  output logic [wbcms_pkg::COL_W-1:0]  rem
);
  import wbcms_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [31:0]       dvd_r, dvd_nxt;
  logic [CCNT_W-1:0] rem_r, rem_nxt;
  logic [CCNT_W-1:0] div_r, div_nxt;
  logic [CCNT_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    trial    = {rem_r, dvd_r[31]};
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[30:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = CCNT_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[CCNT_W-1:0];
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r[COL_W-1:0];

  `WBCMS_CHECK(a_rem_below_div, done_r |-> (rem_r < div_r), "remainder not below divisor")
  `WBCMS_CHECK(a_start_clears, start |=> !done_r, "done set right after start")
  `WBCMS_CHECK(a_busy_not_done, busy_r |-> !done_r, "busy and done together")

endmodule

// ===== sv/word_bigram_count_min_sketch_unit.sv =====
// ----------------------------------------------------------------------------
// word_bigram_count_min_sketch_unit
// Word and word-pair count-min sketch over a text byte stream.
// ----------------------------------------------------------------------------
// A word end runs, per row, two remainders in the shared serial divider, each
// followed by a counter read-modify-write.
// One item in flight; the next is taken once the result is in the output register.
// Reset: sync active low; a clearing pass then zeroes the counters, during which
// no item is taken; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`include "word_bigram_count_min_sketch_unit_macros.svh"

module word_bigram_count_min_sketch_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_func,
  input  logic [7:0]                   in_char_byte,
  input  logic [wbcms_pkg::ROW_W-1:0]  in_row,
  input  logic [wbcms_pkg::COL_W-1:0]  in_column,
  input  logic                         in_coef_select,
  input  logic [31:0]                  in_coef_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_word_done,
  output logic [31:0]                  out_word_hash,
  output logic [31:0]                  out_pair_hash,
  output logic [31:0]                  out_count,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import wbcms_pkg::*;

  state_t state_r, state_nxt;

  logic [31:0]       seed_r;
  logic [CCNT_W-1:0] ccnt_r;
  logic [CCNT_W-1:0] eff_cols;

  logic [31:0]       run_r, run_nxt;
  logic [23:0]       part_r, part_nxt;
  logic [31:0]       len_r, len_nxt;
  logic              inw_r, inw_nxt;
  logic [31:0]       prev_r, prev_nxt;
  logic [7:0]        ch_r, ch_nxt;
  logic              nl_r, nl_nxt;
  logic [31:0]       hw_r, hw_nxt;
  logic [31:0]       hash_r, hash_nxt;
  logic [31:0]       pair_r, pair_nxt;
  logic [31:0]       prod_r;
  logic [31:0]       a_r, a_nxt;
  logic [31:0]       b_r, b_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              sel_r, sel_nxt;
  logic              done_r, done_nxt;
  logic [31:0]       count_r, count_nxt;
  logic [CNT_AW-1:0] clr_r, clr_nxt;
  logic [COEF_DEPTH-1:0] cv_r, cv_nxt;

  logic        out_valid_r;
  logic        out_done_r;
  logic [31:0] out_hash_r, out_pair_r, out_count_r;
  logic        out_load;
  logic        accept;
  logic        cfg_we;

  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_full;
  logic [31:0] mix_h, mix_r, fm_t, fm1, fm2, fm3;

  logic               coef_we;
  logic [COEF_AW-1:0] coef_waddr, coef_raddr;
  logic [31:0]        coef_rdata;
  logic               cnt_we;
  logic [CNT_AW-1:0]  cnt_waddr, cnt_raddr;
  logic [31:0]        cnt_wdata, cnt_rdata;
  logic               mod_start, mod_done;
  logic [31:0]        mod_dvd;
  logic [COL_W-1:0]   mod_rem;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_COLS) ? {{(32-CCNT_W){1'b0}}, ccnt_r} : seed_r;

  always_comb begin
    if (ccnt_r == '0) begin
      eff_cols = CCNT_W'(1);
    end else if (ccnt_r > CCNT_W'(COLUMNS)) begin
      eff_cols = CCNT_W'(COLUMNS);
    end else begin
      eff_cols = ccnt_r;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // shared multiplier
  always_comb begin
    case (state_r)
      S_MIX1:  begin mul_x = {ch_r, part_r};      mul_y = MIX_C1; end
      S_TAIL1: begin mul_x = {8'h00, part_r};     mul_y = MIX_C1; end
      S_MIX2,
      S_TAIL2: begin mul_x = rotl15(prod_r);      mul_y = MIX_C2; end
      S_FMIX1: begin mul_x = fm1;                 mul_y = FIN_M1; end
      S_FMIX2: begin mul_x = fm2;                 mul_y = FIN_M2; end
      S_MULH:  begin mul_x = a_r; mul_y = sel_r ? hash_r : pair_r; end
      default: begin mul_x = '0;                  mul_y = '0;     end
    endcase
  end

  assign mul_full = mul_x * mul_y;
  assign mix_h    = run_r ^ prod_r;
  assign mix_r    = rotl13(mix_h);
  assign fm_t     = hw_r ^ len_r;
  assign fm1      = fm_t ^ (fm_t >> 16);
  assign fm2      = prod_r ^ (prod_r >> 13);
  assign fm3      = prod_r ^ (prod_r >> 16);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == CNT_AW'(CNT_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_OUT;
          if (in_func == FUNC_BYTE) begin
            if (is_word_byte(in_char_byte)) begin
              if (inw_r && (len_r[1:0] == 2'd3)) state_nxt = S_MIX1;
            end else if (inw_r) begin
              state_nxt = (len_r[1:0] != 2'd0) ? S_TAIL1 : S_FMIX1;
            end
          end else if (in_func == FUNC_READ) begin
            if (in_row < ROW_W'(ROWS)) state_nxt = S_RDC;
          end
        end
      end
      S_MIX1:  state_nxt = S_MIX2;
      S_MIX2:  state_nxt = S_MIX3;
      S_MIX3:  state_nxt = S_OUT;
      S_TAIL1: state_nxt = S_TAIL2;
      S_TAIL2: state_nxt = S_TAIL3;
      S_TAIL3: state_nxt = S_FMIX1;
      S_FMIX1: state_nxt = S_FMIX2;
      S_FMIX2: state_nxt = S_FMIX3;
      S_FMIX3: state_nxt = S_RDA;
      S_RDA:   state_nxt = S_RDB;
      S_RDB:   state_nxt = S_MULH;
      S_MULH:  state_nxt = S_MODS;
      S_MODS:  state_nxt = S_DIV;
      S_DIV:   if (mod_done) state_nxt = S_CRD;
      S_CRD:   state_nxt = S_CWR;
      S_CWR: begin
        if (!sel_r) begin
          state_nxt = S_MULH;
        end else if (row_r == ROW_W'(ROWS - 1)) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_RDA;
        end
      end
      S_RDC:   state_nxt = S_RDC2;
      S_RDC2:  state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    run_nxt   = run_r;
    part_nxt  = part_r;
    len_nxt   = len_r;
    inw_nxt   = inw_r;
    prev_nxt  = prev_r;
    ch_nxt    = ch_r;
    nl_nxt    = nl_r;
    hw_nxt    = hw_r;
    hash_nxt  = hash_r;
    pair_nxt  = pair_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    sel_nxt   = sel_r;
    done_nxt  = done_r;
    count_nxt = count_r;
    clr_nxt   = clr_r;
    cv_nxt    = cv_r;

    coef_we    = 1'b0;
    coef_waddr = {in_row, in_coef_select};
    coef_raddr = {row_r, 1'b0};
    cnt_we     = 1'b0;
    cnt_waddr  = {row_r, mod_rem};
    cnt_wdata  = cnt_rdata + 32'd1;
    cnt_raddr  = {row_r, mod_rem};
    mod_start  = 1'b0;
    mod_dvd    = prod_r + b_r;

    case (state_r)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        cnt_wdata = '0;
        clr_nxt   = clr_r + CNT_AW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          done_nxt  = 1'b0;
          count_nxt = '0;
          ch_nxt    = in_char_byte;
          row_nxt   = in_row;
          col_nxt   = in_column;
          case (in_func)
            FUNC_BYTE: begin
              if (is_word_byte(in_char_byte)) begin
                if (!inw_r) begin
                  inw_nxt  = 1'b1;
                  run_nxt  = seed_r;
                  part_nxt = {16'h0000, in_char_byte};
                  len_nxt  = 32'd1;
                end else begin
                  len_nxt = len_r + 32'd1;
                  case (len_r[1:0])
                    2'd0:    part_nxt[7:0]   = in_char_byte;
                    2'd1:    part_nxt[15:8]  = in_char_byte;
                    2'd2:    part_nxt[23:16] = in_char_byte;
                    default: part_nxt        = part_r;
                  endcase
                end
              end else begin
                nl_nxt = (in_char_byte == CH_NL);
                if (inw_r) begin
                  hw_nxt = run_r;
                end else begin
                  part_nxt = '0;
                  len_nxt  = '0;
                  if (in_char_byte == CH_NL) prev_nxt = '0;
                end
              end
            end
            FUNC_LOAD: begin
              if (in_row < ROW_W'(ROWS)) begin
                coef_we            = 1'b1;
                cv_nxt[coef_waddr] = 1'b1;
              end
            end
            default: count_nxt = '0;
          endcase
        end
      end
      S_MIX3: begin
        run_nxt  = mix_r + {mix_r[29:0], 2'b00} + MIX_ADD;
        part_nxt = '0;
      end
      S_TAIL3: hw_nxt = run_r ^ prod_r;
      S_FMIX3: begin
        hash_nxt = fm3;
        pair_nxt = fm3 ^ prev_r;
        row_nxt  = '0;
        sel_nxt  = 1'b0;
        inw_nxt  = 1'b0;
        part_nxt = '0;
        len_nxt  = '0;
      end
      S_RDA: coef_raddr = {row_r, 1'b0};
      S_RDB: begin
        coef_raddr = {row_r, 1'b1};
        a_nxt      = cv_r[{row_r, 1'b0}] ? coef_rdata : 32'd0;
      end
      S_MULH: begin
        if (!sel_r) b_nxt = cv_r[{row_r, 1'b1}] ? coef_rdata : 32'd0;
      end
      S_MODS: mod_start = 1'b1;
      S_CWR: begin
        cnt_we = 1'b1;
        if (!sel_r) begin
          sel_nxt = 1'b1;
        end else if (row_r == ROW_W'(ROWS - 1)) begin
          prev_nxt = nl_r ? 32'd0 : hash_r;
          done_nxt = 1'b1;
        end else begin
          row_nxt = row_r + ROW_W'(1);
          sel_nxt = 1'b0;
        end
      end
      S_RDC:  cnt_raddr = {row_r, col_r};
      S_RDC2: count_nxt = cnt_rdata;
      default: done_nxt = done_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      seed_r      <= SEED_RESET;
      ccnt_r      <= CCNT_RESET;
      inw_r       <= 1'b0;
      part_r      <= '0;
      len_r       <= '0;
      prev_r      <= '0;
      cv_r        <= '0;
      out_valid_r <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      inw_r   <= inw_nxt;
      part_r  <= part_nxt;
      len_r   <= len_nxt;
      prev_r  <= prev_nxt;
      cv_r    <= cv_nxt;
      done_r  <= done_nxt;
      if (cfg_we && (paddr[2] == REG_SEED)) seed_r <= pwdata;
      if (cfg_we && (paddr[2] == REG_COLS)) ccnt_r <= pwdata[CCNT_W-1:0];
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    run_r   <= run_nxt;
    ch_r    <= ch_nxt;
    nl_r    <= nl_nxt;
    hw_r    <= hw_nxt;
    hash_r  <= hash_nxt;
    pair_r  <= pair_nxt;
    prod_r  <= mul_full[31:0];
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    sel_r   <= sel_nxt;
    count_r <= count_nxt;
    if (out_load) begin
      out_done_r  <= done_r;
      out_hash_r  <= done_r ? hash_r : 32'd0;
      out_pair_r  <= done_r ? pair_r : 32'd0;
      out_count_r <= count_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_word_done = out_done_r;
  assign out_word_hash = out_hash_r;
  assign out_pair_hash = out_pair_r;
  assign out_count     = out_count_r;

  wbcms_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (in_coef_value),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  wbcms_ram #(.WIDTH(32), .DEPTH(CNT_DEPTH)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  wbcms_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (eff_cols),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  `WBCMS_CHECK(a_clear_blocks, (state_r == S_CLEAR) |-> in_stall, "item taken during clear")
  `WBCMS_CHECK(a_cnt_row_range, cnt_we |-> (cnt_waddr[CNT_AW-1:COL_W] < ROW_W'(ROWS)), "counter write out of rows")
  `WBCMS_CHECK(a_out_from_seq, $rose(out_valid_r) |-> $past(state_r == S_OUT), "result without sequencer")

endmodule
